// ----- design/srec_pkg.sv -----
`timescale 1ns / 1ps

package srec_pkg;

    localparam logic [1:0] CMD_NAME = 2'd0;
    localparam logic [1:0] CMD_HDR  = 2'd1;
    localparam logic [1:0] CMD_DATA = 2'd2;
    localparam logic [1:0] CMD_FIN  = 2'd3;

    localparam logic [1:0] REC_S0 = 2'd0;
    localparam logic [1:0] REC_S3 = 2'd1;
    localparam logic [1:0] REC_S7 = 2'd2;

    localparam logic [1:0] WORD_TYPE = 2'd0;
    localparam logic [1:0] WORD_HEX  = 2'd1;
    localparam logic [1:0] WORD_NL   = 2'd2;

    localparam logic [1:0] BSEL_COUNT = 2'd0;
    localparam logic [1:0] BSEL_ADDR  = 2'd1;
    localparam logic [1:0] BSEL_DATA  = 2'd2;
    localparam logic [1:0] BSEL_CHK   = 2'd3;

    localparam logic [31:0] BASE_RESET = 32'h2000_0000;

    localparam logic [7:0] S0_COUNT_BASE = 8'd3;
    localparam logic [7:0] S3_COUNT_BASE = 8'd5;
    localparam logic [7:0] S7_COUNT      = 8'd5;

    localparam logic [6:0] CH_S    = 7'h53;
    localparam logic [6:0] CH_NL   = 7'h0A;
    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_A_M10 = 7'h37;

    localparam logic [1:0] CNT_PAIR   = 2'd2;
    localparam logic [1:0] CNT_SINGLE = 2'd1;

    typedef struct packed {
        logic       emit;
        logic [1:0] word;
        logic [1:0] rec;
        logic [1:0] bsel;
        logic [1:0] abyte;
        logic       last;
        logic       wr_name;
        logic       wr_data;
        logic       idx_clr;
        logic       idx_inc;
        logic       flush_done;
        logic       fin_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_empty;
        logic fill_almost;
        logic data_empty;
        logic data_last;
    } t_dp_sts;

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] v;
        v = {3'b000, d};
        if (d < 4'd10) begin
            return CH_ZERO + v;
        end
        return CH_A_M10 + v;
    endfunction

    function automatic logic [6:0] rec_char(input logic [1:0] rec);
        logic [6:0] c;
        case (rec)
            REC_S0:  c = CH_ZERO;
            REC_S3:  c = CH_ZERO + 7'd3;
            REC_S7:  c = CH_ZERO + 7'd7;
            default: c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ----- design/srec_ram.sv -----
`timescale 1ns / 1ps

module srec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/srec_ctrl.sv -----
`timescale 1ns / 1ps

module srec_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_cmd,
    output logic                o_in_ready,
    input  srec_pkg::t_dp_sts   i_sts,
    output srec_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TYPE  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_CHK   = 3'd5;
    localparam logic [2:0] ST_NL    = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_rec, n_rec;
    logic [1:0] r_abyte, n_abyte;
    logic       r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rec   <= srec_pkg::REC_S0;
            r_abyte <= 2'd0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rec   <= n_rec;
            r_abyte <= n_abyte;
            r_fin   <= n_fin;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_rec   = r_rec;
        n_abyte = r_abyte;
        n_fin   = r_fin;
        o_cmd       = '0;
        o_cmd.rec   = r_rec;
        o_cmd.abyte = r_abyte;
        o_cmd.word  = srec_pkg::WORD_HEX;
        o_cmd.bsel  = srec_pkg::BSEL_COUNT;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        srec_pkg::CMD_NAME: begin
                            o_cmd.wr_name = 1'b1;
                        end
                        srec_pkg::CMD_HDR: begin
                            n_rec   = srec_pkg::REC_S0;
                            n_fin   = 1'b0;
                            n_state = ST_TYPE;
                        end
                        srec_pkg::CMD_DATA: begin
                            o_cmd.wr_data = 1'b1;
                            if (i_sts.fill_almost) begin
                                n_rec   = srec_pkg::REC_S3;
                                n_fin   = 1'b0;
                                n_state = ST_TYPE;
                            end
                        end
                        default: begin
                            n_fin   = 1'b1;
                            n_rec   = i_sts.fill_empty ? srec_pkg::REC_S7 : srec_pkg::REC_S3;
                            n_state = ST_TYPE;
                        end
                    endcase
                end
            end
            ST_TYPE: begin
                o_cmd.word = srec_pkg::WORD_TYPE;
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_COUNT;
                end
            end
            ST_COUNT: begin
                o_cmd.bsel = srec_pkg::BSEL_COUNT;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_abyte    = (r_rec == srec_pkg::REC_S0) ? 2'd1 : 2'd3;
                    n_state    = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.bsel = srec_pkg::BSEL_ADDR;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_abyte != 2'd0) begin
                        n_abyte = r_abyte - 2'd1;
                    end else if (r_rec == srec_pkg::REC_S7 || i_sts.data_empty) begin
                        n_state = ST_CHK;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                o_cmd.bsel = srec_pkg::BSEL_DATA;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.data_last) begin
                        n_state = ST_CHK;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_CHK: begin
                o_cmd.bsel = srec_pkg::BSEL_CHK;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_NL;
                end
            end
            ST_NL: begin
                o_cmd.word = srec_pkg::WORD_NL;
                o_cmd.last = !(r_rec == srec_pkg::REC_S3 && r_fin);
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_rec == srec_pkg::REC_S3) begin
                        o_cmd.flush_done = 1'b1;
                        if (r_fin) begin
                            n_rec   = srec_pkg::REC_S7;
                            n_state = ST_TYPE;
                        end
                    end else if (r_rec == srec_pkg::REC_S7) begin
                        o_cmd.fin_done = 1'b1;
                        n_fin          = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/srec_dp.sv -----
`timescale 1ns / 1ps

module srec_dp #(
    parameter int RECORD_BYTES = 32,
    parameter int NAME_BYTES   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_data_byte,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [6:0]         o_first_char,
    output logic [6:0]         o_second_char,
    output logic [1:0]         o_char_count,
    output logic               o_out_last,
    input  srec_pkg::t_dp_cmd  i_cmd,
    output srec_pkg::t_dp_sts  o_sts
);

    localparam int NCW = $clog2(NAME_BYTES + 1);
    localparam int RCW = $clog2(RECORD_BYTES + 1);
    localparam int NAW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int RAW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int IW  = (NCW > RCW) ? NCW : RCW;

    logic [NCW-1:0] r_name_len;
    logic [RCW-1:0] r_fill;
    logic [31:0]    r_base;
    logic [31:0]    r_cur;
    logic [IW-1:0]  r_idx, n_idx;
    logic [7:0]     r_sum;
    logic           r_out_valid;
    logic [6:0]     r_first, n_first;
    logic [6:0]     r_second, n_second;
    logic [1:0]     r_count, n_count;
    logic           r_last;

    logic           name_we;
    logic [7:0]     name_rdata;
    logic [7:0]     rec_rdata;
    logic [IW-1:0]  len_sel;
    logic [31:0]    addr_word;
    logic [7:0]     cur_byte;

    assign name_we = i_cmd.wr_name && (r_name_len < NCW'(NAME_BYTES));

    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    srec_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (r_name_len[NAW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (n_idx[NAW-1:0]),
        .o_rdata (name_rdata)
    );

    srec_ram #(.WIDTH(8), .DEPTH(RECORD_BYTES)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_data),
        .i_waddr (r_fill[RAW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (n_idx[RAW-1:0]),
        .o_rdata (rec_rdata)
    );

    assign len_sel = (i_cmd.rec == srec_pkg::REC_S0) ? IW'(r_name_len) : IW'(r_fill);

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.fill_empty  = (r_fill == '0);
    assign o_sts.fill_almost = (r_fill == RCW'(RECORD_BYTES - 1));
    assign o_sts.data_empty  = (len_sel == '0);
    assign o_sts.data_last   = ((r_idx + IW'(1)) == len_sel);

    always_comb begin
        case (i_cmd.rec)
            srec_pkg::REC_S3: addr_word = r_cur;
            srec_pkg::REC_S7: addr_word = r_base;
            default:          addr_word = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.bsel)
            srec_pkg::BSEL_COUNT: begin
                case (i_cmd.rec)
                    srec_pkg::REC_S0: cur_byte = 8'(r_name_len) + srec_pkg::S0_COUNT_BASE;
                    srec_pkg::REC_S3: cur_byte = 8'(r_fill) + srec_pkg::S3_COUNT_BASE;
                    default:          cur_byte = srec_pkg::S7_COUNT;
                endcase
            end
            srec_pkg::BSEL_ADDR: cur_byte = addr_word[{i_cmd.abyte, 3'b000} +: 8];
            srec_pkg::BSEL_DATA: begin
                cur_byte = (i_cmd.rec == srec_pkg::REC_S0) ? name_rdata : rec_rdata;
            end
            default: cur_byte = ~r_sum;
        endcase
    end

    always_comb begin
        case (i_cmd.word)
            srec_pkg::WORD_TYPE: begin
                n_first  = srec_pkg::CH_S;
                n_second = srec_pkg::rec_char(i_cmd.rec);
                n_count  = srec_pkg::CNT_PAIR;
            end
            srec_pkg::WORD_NL: begin
                n_first  = srec_pkg::CH_NL;
                n_second = 7'd0;
                n_count  = srec_pkg::CNT_SINGLE;
            end
            default: begin
                n_first  = srec_pkg::hex_char(cur_byte[7:4]);
                n_second = srec_pkg::hex_char(cur_byte[3:0]);
                n_count  = srec_pkg::CNT_PAIR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len  <= '0;
            r_fill      <= '0;
            r_base      <= srec_pkg::BASE_RESET;
            r_cur       <= srec_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (name_we) begin
                r_name_len <= r_name_len + NCW'(1);
            end
            if (i_cmd.wr_data) begin
                r_fill <= r_fill + RCW'(1);
            end
            if (i_cmd.flush_done) begin
                r_fill <= '0;
                r_cur  <= r_cur + 32'(RECORD_BYTES);
            end
            if (i_cmd.fin_done) begin
                r_fill <= '0;
                r_cur  <= r_base;
            end
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
                r_cur  <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.emit && i_cmd.word == srec_pkg::WORD_TYPE) begin
            r_sum <= 8'd0;
        end else if (i_cmd.emit && i_cmd.word == srec_pkg::WORD_HEX
                     && i_cmd.bsel != srec_pkg::BSEL_CHK) begin
            r_sum <= r_sum + cur_byte;
        end
        if (i_cmd.emit) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_count  <= n_count;
            r_last   <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_first_char  = r_first;
    assign o_second_char = r_second;
    assign o_char_count  = r_count;
    assign o_out_last    = r_last;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("word loaded over an untaken word");

    a_fill_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_data |-> (r_fill < RCW'(RECORD_BYTES)))
        else $error("data byte written into a full record buffer");

    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush_done |=> (r_fill == '0))
        else $error("record fill not cleared after flush");

    a_fin_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_done |=> (r_cur == r_base))
        else $error("current address not reloaded after finish");
`endif

endmodule

// ----- design/srecord_s3_encoder_core.sv -----
`timescale 1ns / 1ps

// S-record encoder: turns name and data bytes into S0/S3/S7 text, one
// or two characters per output word.
// Input stream: tuser carries the command (name byte, header end, data
// byte, finish), tdata carries the byte for name and data commands.
// Output stream: tdata carries first_char, second_char and char_count;
// tlast marks the final word caused by one input word.
// A name byte, or a data byte that does not complete a record, is taken
// and yields nothing, the input side staying ready. Header end, the data
// byte that fills a record, and finish take the input side off ready until
// the last word of the record text is loaded (on finish with data, of S7).
// Each output word is loaded once the output register is free; the first
// word of a record is loaded in the TYPE state after the command is taken.
// A full 32-byte record is 40 words, and the input side is not ready for
// another data byte while the 40 words of each record go out.
// Receiver stall: the output register holds its word and the sequencer
// waits; no word is dropped.
// Reset clears name length, record fill and the output valid, and loads
// base and current address with 0x20000000. A write on the config port
// loads both base and current address.
module srecord_s3_encoder_core #(
    parameter int RECORD_BYTES = 32,
    parameter int NAME_BYTES   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic [1:0]  i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // first_char, second_char, char_count
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    srec_pkg::t_dp_cmd cmd;
    srec_pkg::t_dp_sts sts;
    logic [6:0]        first_char;
    logic [6:0]        second_char;
    logic [1:0]        char_count;

    srec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srec_dp #(
        .RECORD_BYTES (RECORD_BYTES),
        .NAME_BYTES   (NAME_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_s_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_first_char  (first_char),
        .o_second_char (second_char),
        .o_char_count  (char_count),
        .o_out_last    (o_m_axis_tlast),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    assign o_m_axis_tdata = {char_count, second_char, first_char};

endmodule
